// ----- rtl/pin_guarded_secret_slots_macros.svh -----
// Assertion macros shared by the checker of the secret slot store.
// No dependencies; include by bare file name.
`ifndef PIN_GUARDED_SECRET_SLOTS_MACROS_SVH
`define PIN_GUARDED_SECRET_SLOTS_MACROS_SVH

// Same-cycle implication, switched off while reset is held
`define PGSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pgss assertion failed");

// Next-cycle implication, switched off while reset is held
`define PGSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pgss assertion failed");

`endif

// ----- rtl/pgss_pkg.sv -----
// Shared types and constants of the PIN guarded secret slot store.
// No dependencies; imported by every module of the block but pgss_ram.
`default_nettype none

package pgss_pkg;

    // Store geometry
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_IN_W  = 8;

    // Field widths
    localparam int PIN_W    = 32;
    localparam int SECRET_W = 64;
    localparam int COUNT_W  = 8;
    localparam int OUTC_W   = 2;

    // Stream payload layout
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 136;

    // Lock limit after reset
    localparam logic [COUNT_W-1:0] LOCK_LIMIT_RESET = 8'd10;

    // Command codes
    typedef enum logic [1:0] {
        ACT_STATUS   = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_STORE    = 2'd2,
        ACT_RETRIEVE = 2'd3
    } action_t;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUTC_REFUSED  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_EMPTY    = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_OCCUPIED = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_STORED   = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_WRONG    = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_GRANTED  = 2'd2;

    // One slot entry as held in the slot memory
    typedef struct packed {
        logic [COUNT_W-1:0]  wrong_count;
        logic [PIN_W-1:0]    pin;
        logic [SECRET_W-1:0] secret_low;
        logic [SECRET_W-1:0] secret_high;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Incoming request
    typedef struct packed {
        action_t               action;
        logic [SLOT_IN_W-1:0]  slot;
        logic [PIN_W-1:0]      pin;
        logic [SECRET_W-1:0]   secret_low;
        logic [SECRET_W-1:0]   secret_high;
    } request_t;

    // Request held during its read-modify-write
    typedef struct packed {
        action_t             action;
        logic [SLOT_AW-1:0]  slot;
        logic [PIN_W-1:0]    pin;
        logic [SECRET_W-1:0] secret_low;
        logic [SECRET_W-1:0] secret_high;
    } held_req_t;

    // Slot memory access from the engine
    typedef struct packed {
        logic [SLOT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SLOT_AW-1:0] wr_addr;
        entry_t             wr_data;
    } ram_req_t;

    // Result item
    typedef struct packed {
        logic [OUTC_W-1:0]   outcome;
        logic [SECRET_W-1:0] reply_secret_low;
        logic [SECRET_W-1:0] reply_secret_high;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/pgss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pgss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/pgss_engine.sv -----
// Command sequencer of the secret slot store: read-modify-write of one slot
// entry per request. Depends on pgss_pkg; drives the slot memory.
`default_nettype none

module pgss_engine (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire pgss_pkg::request_t          req,
    input  wire logic [pgss_pkg::COUNT_W-1:0] lock_limit,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output pgss_pkg::result_t                res,
    output pgss_pkg::ram_req_t               ram_req,
    input  wire pgss_pkg::entry_t            ram_rdata
);
    import pgss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    held_req_t             held_reg, held_next;
    logic [SLOT_COUNT-1:0] occupied_reg, occupied_next;

    logic   accept;
    logic   in_range;
    logic   occ;
    logic   finish;
    entry_t entry;

    assign accept    = req_valid && req_ready;
    assign in_range  = {1'b0, req.slot} < (SLOT_IN_W + 1)'(SLOT_COUNT);
    assign req_ready = (state_reg == ST_IDLE);
    assign occ       = occupied_reg[held_reg.slot];
    assign entry     = ram_rdata;
    assign res_valid = (state_reg == ST_EXEC);
    assign finish    = res_valid && res_ready;

    // Decide the outcome and the write-back for the held request
    always_comb begin
        // Read the addressed slot on acceptance, keep reading it while stalled
        ram_req.rd_addr = (state_reg == ST_IDLE) ? req.slot[SLOT_AW-1:0] : held_reg.slot;
        ram_req.wr_addr = held_reg.slot;

        res.outcome           = OUTC_REFUSED;
        res.reply_secret_low  = '0;
        res.reply_secret_high = '0;
        ram_req.wr_en         = 1'b0;
        ram_req.wr_data       = entry;
        occupied_next         = occupied_reg;

        case (held_reg.action)
            ACT_STATUS: begin
                res.outcome = occ ? OUTC_OCCUPIED : OUTC_EMPTY;
            end
            ACT_DELETE: begin
                res.outcome = occ ? OUTC_OCCUPIED : OUTC_EMPTY;
                if (finish) begin
                    occupied_next[held_reg.slot] = 1'b0;
                end
            end
            ACT_STORE: begin
                if (!occ) begin
                    res.outcome                 = OUTC_STORED;
                    ram_req.wr_en               = finish;
                    ram_req.wr_data.wrong_count = '0;
                    ram_req.wr_data.pin         = held_reg.pin;
                    ram_req.wr_data.secret_low  = held_reg.secret_low;
                    ram_req.wr_data.secret_high = held_reg.secret_high;
                    if (finish) begin
                        occupied_next[held_reg.slot] = 1'b1;
                    end
                end
            end
            ACT_RETRIEVE: begin
                if (!occ || (entry.wrong_count >= lock_limit)) begin
                    res.outcome = OUTC_REFUSED;
                end else if (entry.pin != held_reg.pin) begin
                    res.outcome                 = OUTC_WRONG;
                    ram_req.wr_en               = finish;
                    ram_req.wr_data.wrong_count = entry.wrong_count + COUNT_W'(1);
                end else begin
                    res.outcome                 = OUTC_GRANTED;
                    res.reply_secret_low        = entry.secret_low;
                    res.reply_secret_high       = entry.secret_high;
                    ram_req.wr_en               = finish;
                    ram_req.wr_data.wrong_count = '0;
                end
            end
            default: begin
                res.outcome = OUTC_REFUSED;
            end
        endcase
    end

    // Sequence: take a request, then complete it once the result is taken
    always_comb begin
        state_next = state_reg;
        held_next  = held_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_range) begin
                    held_next.action      = req.action;
                    held_next.slot        = req.slot[SLOT_AW-1:0];
                    held_next.pin         = req.pin;
                    held_next.secret_low  = req.secret_low;
                    held_next.secret_high = req.secret_high;
                    state_next            = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occupied_reg <= '0;
        end else begin
            state_reg    <= state_next;
            occupied_reg <= occupied_next;
        end
    end

    // Payload of the held request
    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

// ----- rtl/pin_guarded_secret_slots.sv -----
// PIN guarded secret slot store: a request stream in, a result stream out.
// The request carries an action in s_tuser and slot, PIN and secret in s_tdata.
// The lock limit is written through cfg_wr_en / cfg_wr_data at any idle time.
// Each request for a slot below SLOT_COUNT yields one result: status and
// delete report occupancy, store fills an empty slot, retrieve checks the
// PIN against the stored one and returns the secret when it matches and
// the wrong-guess counter is below the lock limit. Requests for slots at or
// above SLOT_COUNT are taken and dropped without a result.
// Requests are taken one at a time: the read-modify-write of the slot memory
// (a registered read, then decide and write back) must finish, and its result
// be taken into the output register, before the next request is accepted.
// The output register lets a new request in while a result waits.
// Reset clears every occupied mark and restores the lock limit to 10; no
// memory clearing pass is run. When m_tready is low, the pending result
// holds in the output register and the next request holds in the engine.
// Depends on pgss_pkg, pgss_engine and pgss_ram.
`default_nettype none

module pin_guarded_secret_slots (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Request channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] slot, [39:8] pin_value, [103:40] secret_low, [167:104] secret_high
    input  wire logic [pgss_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] action
    input  wire logic [1:0]                       s_tuser,
    // Result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [1:0] outcome, [65:2] reply_secret_low, [129:66] reply_secret_high,
    // [135:130] zero
    output logic      [pgss_pkg::M_TDATA_W-1:0]   m_tdata,
    // Lock limit register
    input  wire logic                             cfg_wr_en,
    input  wire logic [pgss_pkg::COUNT_W-1:0]     cfg_wr_data
);
    import pgss_pkg::*;

    logic [COUNT_W-1:0] lock_limit_reg;
    logic               m_tvalid_reg;
    result_t            result_reg;

    request_t  req;
    result_t   res;
    logic      res_valid;
    logic      res_ready;
    ram_req_t  ram_req;
    entry_t    ram_rdata;
    logic [ENTRY_W-1:0] ram_rd_bits;

    // Unpack the request
    always_comb begin
        req.action      = action_t'(s_tuser);
        req.slot        = s_tdata[7:0];
        req.pin         = s_tdata[39:8];
        req.secret_low  = s_tdata[103:40];
        req.secret_high = s_tdata[167:104];
    end

    // Lock limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_limit_reg <= LOCK_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            lock_limit_reg <= cfg_wr_data;
        end
    end

    pgss_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req         (req),
        .lock_limit  (lock_limit_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    pgss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_bits)
    );

    assign ram_rdata = entry_t'(ram_rd_bits);

    // Output register: load when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            result_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, result_reg.reply_secret_high,
                       result_reg.reply_secret_low, result_reg.outcome};

endmodule

`default_nettype wire

// ----- rtl/pgss_checker.sv -----
// Port-level checker of the secret slot store, bound to the top level.
// Depends on pgss_pkg and pin_guarded_secret_slots_macros.svh.
`default_nettype none

`include "pin_guarded_secret_slots_macros.svh"

module pgss_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [pgss_pkg::M_TDATA_W-1:0] m_tdata
);
    import pgss_pkg::*;

    // A stalled result holds
    `PGSS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // No outcome code above granted
    `PGSS_ASSERT_IMP(a_outcome_code, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)

    // Secret leaves only with a granted retrieve
    `PGSS_ASSERT_IMP(a_secret_gated, aclk, aresetn, m_tvalid && (m_tdata[1:0] != OUTC_GRANTED), m_tdata[129:2] == '0)

    // A new result follows a taken request, through the slot read and the output register
    `PGSS_ASSERT_IMP(a_result_cause, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind pin_guarded_secret_slots pgss_checker u_pgss_checker (.*);

`default_nettype wire
